// ===== hdl/ilps_pkg.sv =====
// ----------------------------------------------------------------------------
// ilps_pkg
// Shared types and constants of the idle link probe selector: field widths,
// link table entry layout, item record, scoring result and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ilps_pkg;

  // Table geometry
  localparam int unsigned LinkSlots = 64;
  localparam int unsigned SlotW     = (LinkSlots > 1) ? $clog2(LinkSlots) : 1;

  // Fixed field widths
  localparam int unsigned LinkIdxW = 6;
  localparam int unsigned CntW     = 32;
  localparam int unsigned TimeW    = 48;

  // Item mode codes
  localparam logic ModeObserve = 1'b0;
  localparam logic ModeRemove  = 1'b1;

  // One link table entry
  typedef struct packed {
    logic [CntW-1:0]  prev_cnt;
    logic [TimeW-1:0] last_chk;
    logic             tgt;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One input item
  typedef struct packed {
    logic                mode;
    logic [LinkIdxW-1:0] link_index;
    logic                has_counter_data;
    logic [CntW-1:0]     tx_packet_count;
    logic                has_address;
    logic [TimeW-1:0]    now_time;
    logic                scan_last;
  } item_t;

  // Scoring decision for one observed link
  typedef struct packed {
    logic             wr_en;
    entry_t           wr_entry;
    logic             take;
    logic [TimeW-1:0] age;
  } score_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIN_RD,
    ST_FIN_WR
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/ilps_if.sv =====
// ----------------------------------------------------------------------------
// ilps_if
// Valid/ready channel interfaces: observation input, result output and the
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilps_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ilps_pkg::LinkIdxW-1:0] link_index;
  logic                          has_counter_data;
  logic [ilps_pkg::CntW-1:0]     tx_packet_count;
  logic                          has_address;
  logic [ilps_pkg::TimeW-1:0]    now_time;
  logic                          scan_last;

  modport source (
    output valid, mode, link_index, has_counter_data, tx_packet_count,
           has_address, now_time, scan_last,
    input  ready
  );
  modport sink (
    input  valid, mode, link_index, has_counter_data, tx_packet_count,
           has_address, now_time, scan_last,
    output ready
  );
endinterface

interface ilps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          winner_found;
  logic                          send_probe;
  logic [ilps_pkg::LinkIdxW-1:0] winner_index;
  logic [ilps_pkg::TimeW-1:0]    winner_age;

  modport source (
    output valid, winner_found, send_probe, winner_index, winner_age,
    input  ready
  );
  modport sink (
    input  valid, winner_found, send_probe, winner_index, winner_age,
    output ready
  );
endinterface

interface ilps_cfg_if;
  logic valid;
  logic ready;
  logic require_traffic_data;

  modport source (
    output valid, require_traffic_data,
    input  ready
  );
  modport sink (
    input  valid, require_traffic_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/idle_link_probe_selector.sv =====
// ----------------------------------------------------------------------------
// idle_link_probe_selector
// Picks the link with the oldest check time during a scan and reports on the
// scan's last item whether it is probed. Link state lives in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                   Handshake
//  in_i     in   mode, link_index, counters, time, last    valid/ready
//  out_o    out  winner_found, send_probe, index, age      valid/ready
//  cfg_i    in   require_traffic_data                      valid/ready
//
//  An observe item is a RAM read, then score and write back.
//  A scan's last item adds a winner read and a winner write back.
//  A removal does not touch the RAM.
//  This order comes from the one RAM port pair doing read-modify-write.
//  Reset clears per-slot valid bits at once; an invalid slot reads as zero.
//  The winner read waits while the output register still holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_link_probe_selector (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ilps_in_if.sink    in_i,
  ilps_out_if.source out_o,
  ilps_cfg_if.sink   cfg_i
);
  import ilps_pkg::*;

  state_e state_q, state_d;

  item_t  item_q;
  logic   rtd_q;

  logic [LinkSlots-1:0] vld_q, vld_d;

  logic [TimeW-1:0] best_age_q;
  logic [SlotW-1:0] best_slot_q;
  logic             best_vld_q;
  logic             best_addr_q;

  logic                out_vld_q;
  logic                out_found_q;
  logic                out_send_q;
  logic [LinkIdxW-1:0] out_idx_q;
  logic [TimeW-1:0]    out_age_q;

  logic              in_acc;
  logic              obs_acc;
  logic              rm_acc;
  logic              rm_ok;
  logic [SlotW-1:0]  rm_slot;
  logic [SlotW-1:0]  item_slot;
  logic              item_ok;

  logic              ram_re;
  logic [SlotW-1:0]  ram_raddr;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic [SlotW-1:0]  rd_slot;
  entry_t            ent_rd;
  score_t            sc;
  logic              fin_send;
  logic              out_load;

  // Handshake decode
  assign in_acc    = in_i.valid && in_i.ready;
  assign obs_acc   = in_acc && (in_i.mode == ModeObserve);
  assign rm_acc    = in_acc && (in_i.mode == ModeRemove);
  assign rm_slot   = SlotW'(in_i.link_index);
  assign rm_ok     = (32'(in_i.link_index) < LinkSlots);
  assign item_slot = SlotW'(item_q.link_index);
  assign item_ok   = (32'(item_q.link_index) < LinkSlots);
  assign cfg_i.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtd_q <= 1'b1;
    end else if (cfg_i.valid) begin
      rtd_q <= cfg_i.require_traffic_data;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (obs_acc) begin
      item_q.mode             <= in_i.mode;
      item_q.link_index       <= in_i.link_index;
      item_q.has_counter_data <= in_i.has_counter_data;
      item_q.tx_packet_count  <= in_i.tx_packet_count;
      item_q.has_address      <= in_i.has_address;
      item_q.now_time         <= in_i.now_time;
      item_q.scan_last        <= in_i.scan_last;
    end
  end

  // Link table
  ilps_ram #(
    .Width (EntryW),
    .Depth (LinkSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry seen by the logic; slots not valid (unwritten or removed) read as zero
  assign rd_slot = (state_q == ST_FIN_WR) ? best_slot_q : item_slot;
  assign ent_rd  = vld_q[rd_slot] ? entry_t'(ram_rdata) : '0;

  ilps_score u_score (
    .item_i     (item_q),
    .entry_i    (ent_rd),
    .rtd_i      (rtd_q),
    .best_age_i (best_age_q),
    .score_o    (sc)
  );

  assign fin_send = best_vld_q && (ent_rd.tgt || best_addr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (obs_acc) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = item_q.scan_last ? ST_FIN_RD : ST_IDLE;
      end
      ST_FIN_RD: begin
        if (!out_vld_q) state_d = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: RAM control and input ready
  always_comb begin
    in_i.ready = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rm_slot;
    ram_we     = 1'b0;
    ram_waddr  = item_slot;
    ram_wdata  = sc.wr_entry;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_re     = obs_acc && rm_ok;
      end
      ST_EVAL: begin
        ram_we = sc.wr_en && item_ok;
      end
      ST_FIN_RD: begin
        ram_re    = !out_vld_q;
        ram_raddr = best_slot_q;
      end
      ST_FIN_WR: begin
        out_load           = 1'b1;
        ram_we             = best_vld_q;
        ram_waddr          = best_slot_q;
        ram_wdata          = ent_rd;
        ram_wdata.last_chk = item_q.now_time;
        ram_wdata.tgt      = ent_rd.tgt || best_addr_q;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // Slot valid bits
  always_comb begin
    vld_d = vld_q;
    if (rm_acc && rm_ok) vld_d[rm_slot] = 1'b0;
    if (ram_we) vld_d[ram_waddr] = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  // Running best of the open scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_age_q  <= '0;
      best_slot_q <= '0;
      best_vld_q  <= 1'b0;
      best_addr_q <= 1'b0;
    end else if (state_q == ST_FIN_WR ||
                 (rm_acc && rm_ok && best_vld_q && best_slot_q == rm_slot)) begin
      best_age_q  <= '0;
      best_slot_q <= '0;
      best_vld_q  <= 1'b0;
      best_addr_q <= 1'b0;
    end else if (state_q == ST_EVAL && sc.take) begin
      best_age_q  <= sc.age;
      best_slot_q <= item_slot;
      best_vld_q  <= 1'b1;
      best_addr_q <= item_q.has_address;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= best_vld_q;
      out_send_q  <= fin_send;
      out_idx_q   <= best_vld_q ? LinkIdxW'(best_slot_q) : '0;
      out_age_q   <= best_vld_q ? best_age_q : '0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.winner_found = out_found_q;
  assign out_o.send_probe   = out_send_q;
  assign out_o.winner_index = out_idx_q;
  assign out_o.winner_age   = out_age_q;

  // Checks
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN_WR))
    else $error("result raised outside winner write back");

  a_send_needs_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_send_q |-> out_found_q)
    else $error("probe sent without a winner");

  a_no_winner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_found_q |-> (out_age_q == '0) && (out_idx_q == '0))
    else $error("empty result carries nonzero fields");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EVAL || state_q == ST_FIN_WR))
    else $error("table write outside evaluate or write back");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN_WR |=> !best_vld_q && (best_age_q == '0))
    else $error("scan best not cleared after scan end");

endmodule

`default_nettype wire

// ===== hdl/ilps_ram.sv =====
// ----------------------------------------------------------------------------
// ilps_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ilps_score.sv =====
// ----------------------------------------------------------------------------
// ilps_score
// Scores one observed link against its table entry: traffic checks, counter
// update, age computation and the compare against the current best age.
// ----------------------------------------------------------------------------
`default_nettype none

module ilps_score (
  input  wire ilps_pkg::item_t            item_i,
  input  wire ilps_pkg::entry_t           entry_i,
  input  wire logic                       rtd_i,
  input  wire logic [ilps_pkg::TimeW-1:0] best_age_i,
  output ilps_pkg::score_t                score_o
);
  import ilps_pkg::*;

  logic             in_range;
  logic             scored;
  logic [TimeW-1:0] age;

  assign in_range = (32'(item_i.link_index) < LinkSlots);
  // modulo 2^48 by width
  assign age      = item_i.now_time - entry_i.last_chk;

  always_comb begin
    score_o          = '0;
    score_o.age      = age;
    score_o.wr_entry = entry_i;
    scored           = in_range;
    if (in_range && rtd_i) begin
      if (!item_i.has_counter_data) begin
        scored = 1'b0;
      end else if (entry_i.prev_cnt != item_i.tx_packet_count) begin
        // fresh traffic: restamp and skip
        scored                    = 1'b0;
        score_o.wr_en             = 1'b1;
        score_o.wr_entry.prev_cnt = item_i.tx_packet_count;
        score_o.wr_entry.last_chk = item_i.now_time;
      end
    end
    score_o.take = scored && (age > best_age_i);
  end

endmodule

`default_nettype wire

// ===== tb/ilps_probe_checker.sv =====
// ----------------------------------------------------------------------------
// ilps_probe_checker
// Watches the input, result and configuration channels of the idle link
// probe selector. It keeps its own copy of the link table and the running
// scan candidate, predicts the result of every scan and checks each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ilps_probe_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ilps_in_if   in_i,
  ilps_out_if  out_i,
  ilps_cfg_if  cfg_i,
  output int   error_count_o,
  output int   pending_o
);
  import ilps_pkg::*;

  // Expected scan outcome
  typedef struct packed {
    logic                found;
    logic                send;
    logic [LinkIdxW-1:0] index;
    logic [TimeW-1:0]    age;
  } decision_t;

  // Shadow link table
  logic [CntW-1:0]     tx_cnt_tbl   [LinkSlots];
  logic [TimeW-1:0]    chk_time_tbl [LinkSlots];
  logic                target_tbl   [LinkSlots];

  // Running scan candidate and register copy
  logic [TimeW-1:0]    cand_age;
  logic [LinkIdxW-1:0] cand_slot;
  logic                cand_valid;
  logic                cand_addr;
  logic                traffic_gate;

  decision_t           decision_q[$];
  int                  mismatches = 0;
  int                  pending_n  = 0;

  assign error_count_o = mismatches;
  assign pending_o     = pending_n;

  task automatic clear_candidate();
    cand_age   = '0;
    cand_slot  = '0;
    cand_valid = 1'b0;
    cand_addr  = 1'b0;
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, label, want, got);
      mismatches++;
    end
  endtask

  // Update the table for one accepted item; a scan's last item queues a result
  task automatic apply_link_item(input item_t it);
    logic [LinkIdxW-1:0] s;
    logic [TimeW-1:0]    age;
    logic                scored;
    decision_t           d;
    s = it.link_index;
    if (it.mode == ModeRemove) begin
      if (int'(s) < LinkSlots) begin
        tx_cnt_tbl[s]   = '0;
        chk_time_tbl[s] = '0;
        target_tbl[s]   = 1'b0;
        if (cand_valid && cand_slot == s) clear_candidate();
      end
    end else begin
      // Score the link unless the traffic gate skips it
      scored = (int'(s) < LinkSlots);
      if (scored && traffic_gate) begin
        if (!it.has_counter_data) begin
          scored = 1'b0;
        end else if (tx_cnt_tbl[s] != it.tx_packet_count) begin
          tx_cnt_tbl[s]   = it.tx_packet_count;
          chk_time_tbl[s] = it.now_time;
          scored          = 1'b0;
        end
      end
      if (scored) begin
        age = it.now_time - chk_time_tbl[s];
        if (age > cand_age) begin
          cand_age   = age;
          cand_slot  = s;
          cand_valid = 1'b1;
          cand_addr  = it.has_address;
        end
      end
      // Close the scan: restamp and mark the winner
      if (it.scan_last) begin
        d = '0;
        if (cand_valid) begin
          chk_time_tbl[cand_slot] = it.now_time;
          if (cand_addr) target_tbl[cand_slot] = 1'b1;
          d.found = 1'b1;
          d.send  = target_tbl[cand_slot];
          d.index = cand_slot;
          d.age   = cand_age;
        end
        decision_q.push_back(d);
        clear_candidate();
      end
    end
  endtask

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t     it;
    decision_t got;
    decision_t want;
    if (!rst_ni) begin
      for (int k = 0; k < LinkSlots; k++) begin
        tx_cnt_tbl[k]   = '0;
        chk_time_tbl[k] = '0;
        target_tbl[k]   = 1'b0;
      end
      clear_candidate();
      traffic_gate = 1'b1;
      decision_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = '{found: out_i.winner_found, send: out_i.send_probe,
                index: out_i.winner_index, age: out_i.winner_age};
        if (decision_q.size() == 0) begin
          $display("%0t: result transaction with none expected, actual 0x%0h",
                   $time, got);
          mismatches++;
        end else begin
          want = decision_q.pop_front();
          check_field("winner_found", want.found, got.found);
          check_field("send_probe", want.send, got.send);
          check_field("winner_index", want.index, got.index);
          check_field("winner_age", want.age, got.age);
        end
      end
      if (cfg_i.valid && cfg_i.ready) traffic_gate = cfg_i.require_traffic_data;
      if (in_i.valid && in_i.ready) begin
        it = '{mode: in_i.mode, link_index: in_i.link_index,
               has_counter_data: in_i.has_counter_data,
               tx_packet_count: in_i.tx_packet_count,
               has_address: in_i.has_address, now_time: in_i.now_time,
               scan_last: in_i.scan_last};
        apply_link_item(it);
      end
    end
    pending_n = decision_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the idle link probe selector with a short directed sequence and
// then random scans under both traffic gate settings, with random gaps on
// the input and result channels and one long result back-pressure stretch.
// The checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ilps_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  int               error_count;
  int               pending;
  logic             idle_free;
  logic             hold_req;
  logic [CntW-1:0]  cnt_seen [LinkSlots];
  logic [TimeW-1:0] scan_now;

  ilps_in_if  in_if();
  ilps_out_if out_if();
  ilps_cfg_if cfg_if();

  idle_link_probe_selector uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  ilps_probe_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .out_i         (out_if),
    .cfg_i         (cfg_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [TimeW-1:0] rand48();
    return TimeW'({$urandom, $urandom});
  endfunction

  // Mostly short gaps, a few long ones, none while idle_free is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (idle_free) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t make_observe(input int slot, input logic has_cnt,
                                         input logic [CntW-1:0] cnt,
                                         input logic addr,
                                         input logic [TimeW-1:0] now,
                                         input logic last);
    item_t it;
    it.mode             = ModeObserve;
    it.link_index       = LinkIdxW'(slot);
    it.has_counter_data = has_cnt;
    it.tx_packet_count  = cnt;
    it.has_address      = addr;
    it.now_time         = now;
    it.scan_last        = last;
    return it;
  endfunction

  // Removal with random filler in the unused fields
  function automatic item_t make_removal(input int slot, input logic last);
    item_t it;
    it = make_observe(slot, 1'($urandom_range(1)), $urandom,
                      1'($urandom_range(1)), rand48(), last);
    it.mode = ModeRemove;
    return it;
  endfunction

  // One input transaction
  task automatic send_link_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.mode             <= it.mode;
    in_if.link_index       <= it.link_index;
    in_if.has_counter_data <= it.has_counter_data;
    in_if.tx_packet_count  <= it.tx_packet_count;
    in_if.has_address      <= it.has_address;
    in_if.now_time         <= it.now_time;
    in_if.scan_last        <= it.scan_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write once all results are in and the block has settled
  task automatic write_traffic_gate(input logic value);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_if.valid                <= 1'b1;
    cfg_if.require_traffic_data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Random scans: mostly well-formed, some removals and some broken scans
  task automatic run_scan_traffic(input int n_items);
    int          sent;
    int          len;
    int          slot;
    int          r;
    logic        broken;
    logic        has_cnt;
    logic        last;
    logic [CntW-1:0]  cnt;
    logic [TimeW-1:0] now;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      r = $urandom_range(99);
      if (r < 85)      scan_now = scan_now + $urandom_range(0, 3000);
      else if (r < 96) scan_now = rand48();
      else             scan_now = 48'hFFFF_FFFF_F000 + $urandom_range(0, 4095);
      broken = ($urandom_range(99) < 6);
      for (int k = 0; k < len; k++) begin
        slot = ($urandom_range(1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
        if ($urandom_range(99) < 7) begin
          cnt_seen[slot] = '0;
          send_link_item(make_removal(slot, 1'($urandom_range(1))));
        end else begin
          has_cnt = ($urandom_range(99) < 88);
          if ($urandom_range(99) < 75) begin
            cnt = cnt_seen[slot];
          end else begin
            cnt = $urandom;
            if (has_cnt) cnt_seen[slot] = cnt;
          end
          last = broken ? 1'($urandom_range(1)) : (k == len - 1);
          now  = broken ? rand48() : scan_now;
          send_link_item(make_observe(slot, has_cnt, cnt, 1'($urandom_range(1)), now,
                                      last));
        end
        sent++;
      end
    end
  endtask

  // Result side: random ready with one long hold-off on request
  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rst_ni                      = 1'b0;
    in_if.valid                 = 1'b0;
    in_if.mode                  = ModeObserve;
    in_if.link_index            = '0;
    in_if.has_counter_data      = 1'b0;
    in_if.tx_packet_count       = '0;
    in_if.has_address           = 1'b0;
    in_if.now_time              = '0;
    in_if.scan_last             = 1'b0;
    cfg_if.valid                = 1'b0;
    cfg_if.require_traffic_data = 1'b0;
    idle_free                   = 1'b0;
    hold_req                    = 1'b0;
    scan_now                    = '0;
    for (int k = 0; k < LinkSlots; k++) cnt_seen[k] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, traffic gate at its reset value
    // link without counters is skipped; scan with no winner
    send_link_item(make_observe(0, 1'b0, '0, 1'b1, 48'd1000, 1'b1));
    // unchanged counter scores, changed counter restamps, a tie does not win
    send_link_item(make_observe(1, 1'b1, '0, 1'b1, 48'd1000, 1'b0));
    send_link_item(make_observe(2, 1'b1, 32'hFFFF_FFFF, 1'b1, 48'd1000, 1'b0));
    send_link_item(make_observe(63, 1'b1, '0, 1'b0, 48'd1000, 1'b1));
    // removal with scan_last set does not close a scan
    send_link_item(make_removal(1, 1'b1));
    // removal of the open scan's candidate drops it
    send_link_item(make_observe(5, 1'b1, '0, 1'b0, 48'd2000, 1'b0));
    send_link_item(make_removal(5, 1'b0));
    send_link_item(make_observe(6, 1'b1, '0, 1'b1, 48'd2000, 1'b1));
    // target stays set after the address is lost
    send_link_item(make_observe(6, 1'b1, '0, 1'b0, 48'd5000, 1'b1));
    // age wraps when the time runs backwards
    send_link_item(make_observe(6, 1'b1, '0, 1'b0, 48'h10, 1'b1));
    // field extremes; zero age never wins
    send_link_item(make_observe(63, 1'b1, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0));
    send_link_item(make_observe(63, 1'b1, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1));
    send_link_item(make_observe(62, 1'b1, '0, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1));
    // winner without address and without target
    send_link_item(make_observe(3, 1'b1, '0, 1'b0, 48'h8000_0000_0000, 1'b1));
    send_link_item(make_removal(62, 1'b0));
    send_link_item(make_observe(62, 1'b1, '0, 1'b1, 48'h8000_0000_0001, 1'b1));
    cnt_seen[2]  = 32'hFFFF_FFFF;
    cnt_seen[63] = 32'hFFFF_FFFF;
    scan_now     = 48'h8000_0000_0001;

    // Random scans across gate settings
    write_traffic_gate(1'b0);
    run_scan_traffic(260);
    write_traffic_gate(1'b1);
    idle_free = 1'b1;
    hold_req  = 1'b1;
    run_scan_traffic(260);
    idle_free = 1'b0;
    write_traffic_gate(1'b0);
    run_scan_traffic(260);
    write_traffic_gate(1'b1);
    run_scan_traffic(270);

    // Drain
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
